@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file rsbd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication at every rising clock edge outside of reset.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a signal holds its value from one cycle to the next when a condition holds.
`define ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> $stable(sig)) else $error(msg);

`endif

@@ hdl/rsbd_pkg.sv @@
package rsbd_pkg;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [31:0] tag;
        logic        last_in;
    } t_in_item;

    typedef struct packed {
        logic [15:0] sorted_year;
        logic [3:0]  sorted_month;
        logic [4:0]  sorted_day;
        logic [31:0] sorted_tag;
        logic        last_out;
        logic        overflow;
    } t_out_item;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [31:0] tag;
    } t_rec;

    typedef struct packed {
        logic insert;
        logic shift_out;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic one_left;
    } t_dp_status;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

endpackage

@@ hdl/rsbd_ctrl.sv @@
module rsbd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_last_in,
    input  rsbd_pkg::t_dp_status i_status,
    output rsbd_pkg::t_dp_cmd   o_cmd,
    output logic                o_busy,
    output logic                o_strobe,
    output logic                o_overflow
);
    import rsbd_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_overflow;
    logic   n_overflow;
    logic   accept;

    assign accept = i_start && (r_state == ST_LOAD);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (accept && i_last_in) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.one_left) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd.insert    = 1'b0;
        o_cmd.shift_out = 1'b0;
        o_busy          = 1'b0;
        o_strobe        = 1'b0;
        n_overflow      = r_overflow;
        case (r_state)
            ST_LOAD: begin
                o_cmd.insert = accept && !i_status.full;
                if (accept && i_status.full) begin
                    n_overflow = 1'b1;
                end
            end
            ST_EMIT: begin
                o_busy          = 1'b1;
                o_strobe        = 1'b1;
                o_cmd.shift_out = 1'b1;
                if (i_status.one_left) begin
                    n_overflow = 1'b0;
                end
            end
            default: begin
                n_overflow = 1'b0;
            end
        endcase
    end

    assign o_overflow = r_overflow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_overflow <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_overflow <= n_overflow;
        end
    end

endmodule

@@ hdl/rsbd_datapath.sv @@
module rsbd_datapath #(
    parameter int MAX_RECORDS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rsbd_pkg::t_dp_cmd    i_cmd,
    input  rsbd_pkg::t_rec       i_rec,
    output rsbd_pkg::t_dp_status o_status,
    output rsbd_pkg::t_rec       o_head
);
    import rsbd_pkg::*;

    t_rec                   r_cell [MAX_RECORDS];
    t_rec                   n_cell [MAX_RECORDS];
    logic [MAX_RECORDS-1:0] r_valid;
    logic [MAX_RECORDS-1:0] n_valid;
    logic [MAX_RECORDS-1:0] gt;
    logic [24:0]            new_key;

    assign new_key = {i_rec.year, i_rec.month, i_rec.day};

    // An empty cell counts as greater than any key, so the new record lands
    // behind every held record whose key is not greater.
    genvar g;
    generate
        for (g = 0; g < MAX_RECORDS; g++) begin : g_cell
            assign gt[g] = !r_valid[g] ||
                ({r_cell[g].year, r_cell[g].month, r_cell[g].day} > new_key);

            if (g == 0) begin : g_first
                always_comb begin
                    n_cell[g] = r_cell[g];
                    if (i_cmd.shift_out) begin
                        n_cell[g] = r_cell[g+1];
                    end else if (i_cmd.insert && gt[g]) begin
                        n_cell[g] = i_rec;
                    end
                end
            end else if (g == MAX_RECORDS - 1) begin : g_last
                always_comb begin
                    n_cell[g] = r_cell[g];
                    if (i_cmd.insert && gt[g]) begin
                        n_cell[g] = gt[g-1] ? r_cell[g-1] : i_rec;
                    end
                end
            end else begin : g_mid
                always_comb begin
                    n_cell[g] = r_cell[g];
                    if (i_cmd.shift_out) begin
                        n_cell[g] = r_cell[g+1];
                    end else if (i_cmd.insert && gt[g]) begin
                        n_cell[g] = gt[g-1] ? r_cell[g-1] : i_rec;
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        n_valid = r_valid;
        if (i_cmd.shift_out) begin
            n_valid = r_valid >> 1;
        end else if (i_cmd.insert) begin
            n_valid = {r_valid[MAX_RECORDS-2:0], 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign o_status.full     = r_valid[MAX_RECORDS-1];
    assign o_status.one_left = !r_valid[1];
    assign o_head            = r_cell[0];

endmodule

@@ hdl/record_sort_by_date.sv @@
// Stable sorter for sets of dated records.
// Input: a record on i_item is taken at a rising edge where start is high
// and busy is low. Each record is placed into a row of sorting cells in
// that same cycle, so one record is taken per cycle while loading.
// A record flagged last_in closes the set. From the next cycle on, busy is
// high and the set comes out on o_result in ascending date order (year,
// month, day), records of equal date in arrival order, one per cycle with
// o_strobe high; last_out marks the final one. A set yields one result
// per held record. Records that arrive while MAX_RECORDS are held are
// dropped and overflow is set on every result of that set. A closing
// record that is dropped still ends the set. Each result is valid for
// exactly one cycle; the receiver cannot stall the output. Reset empties
// the cell row and clears the overflow flag.
module record_sort_by_date #(
    parameter int MAX_RECORDS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  rsbd_pkg::t_in_item   i_item,
    output logic                 busy,
    output logic                 o_strobe,
    output rsbd_pkg::t_out_item  o_result
);
    import rsbd_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    t_rec       new_rec;
    t_rec       head;
    logic       overflow;

    assign new_rec.year  = i_item.year;
    assign new_rec.month = i_item.month;
    assign new_rec.day   = i_item.day;
    assign new_rec.tag   = i_item.tag;

    rsbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_last_in  (i_item.last_in),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_busy     (busy),
        .o_strobe   (o_strobe),
        .o_overflow (overflow)
    );

    rsbd_datapath #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_rec    (new_rec),
        .o_status (status),
        .o_head   (head)
    );

    assign o_result.sorted_year  = head.year;
    assign o_result.sorted_month = head.month;
    assign o_result.sorted_day   = head.day;
    assign o_result.sorted_tag   = head.tag;
    assign o_result.last_out     = status.one_left;
    assign o_result.overflow     = overflow;

endmodule

@@ hdl/rsbd_checker.sv @@
`include "assert_macros.svh"

module rsbd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input rsbd_pkg::t_in_item  i_item,
    input logic                busy,
    input logic                o_strobe,
    input rsbd_pkg::t_out_item o_result
);
    import rsbd_pkg::*;

    `ASSERT_CLKD(a_strobe_busy, i_clk, i_rst_n, o_strobe |-> busy, "result outside of a busy run")
    `ASSERT_CLKD(a_run_contig, i_clk, i_rst_n, (o_strobe && !o_result.last_out) |=> o_strobe, "gap in an output run")
    `ASSERT_CLKD(a_run_end, i_clk, i_rst_n, (o_strobe && o_result.last_out) |=> (!o_strobe && !busy), "block stays busy after the final result")
    `ASSERT_CLKD(a_no_early, i_clk, i_rst_n, (start && !busy && !i_item.last_in) |=> !o_strobe, "result after a transfer that does not close the set")
    `ASSERT_HOLD(a_ovf_hold, i_clk, i_rst_n, o_strobe && !o_result.last_out, o_result.overflow, "overflow changes within a run")

endmodule

bind record_sort_by_date rsbd_checker u_rsbd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_item   (i_item),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
